// File: hw/rtl/isl_pkg.sv
// Package for the indexed sequence list: field widths, request and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package isl_pkg;

    localparam int KIND_W      = 3;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int STATUS_W    = 2;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_FRONT  = 3'd1,
        KIND_END    = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_REMOVE = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_WAIT,
        S_OPEN,
        S_CLOSE,
        S_DRAIN,
        S_PLACE,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    in_ready;
        logic    take;
        logic    ptr_open;
        logic    ptr_close;
        logic    shift_rd;
        logic    shift_up;
        logic    rd_issue;
        logic    rd_capture;
        logic    place;
        logic    cnt_dec;
        logic    set_status;
        status_t status;
        logic    publish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              in_valid;
        logic              out_busy;
        logic [KIND_W-1:0] kind;
        logic              pos_ok;
        logic              full;
        logic              empty;
        logic              at_is_last;
        logic              p_eq_at;
        logic              p_eq_last;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/isl_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on isl_pkg.
`default_nettype none

interface isl_req_if
    import isl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output kind, output item_value, output position,
                    input ready);
    modport sink   (input valid, input kind, input item_value, input position,
                    output ready);
endinterface

interface isl_rsp_if
    import isl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]     status;
    logic [CNT_OUT_W-1:0]    count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/isl_ctrl.sv
// Controller FSM for the indexed sequence list: sequences reads, gap shifts,
// placement and the response. Depends on isl_pkg.
`default_nettype none

module isl_ctrl
    import isl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_FINISH;
                case (stat.kind)
                    KIND_READ:
                    begin
                        if (stat.pos_ok)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_RD_WAIT;
                        end
                        else
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD;
                        end
                    end
                    KIND_FRONT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            cmd.ptr_open = 1'b1;
                            state_next   = S_OPEN;
                        end
                    end
                    KIND_END:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (!stat.pos_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD;
                        end
                        else if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_FULL;
                        end
                        else
                        begin
                            cmd.ptr_open = 1'b1;
                            state_next   = S_OPEN;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!stat.pos_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD;
                        end
                        else if (stat.at_is_last)
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.ptr_close = 1'b1;
                            state_next    = S_CLOSE;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_BAD;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_FINISH;
            end
            S_OPEN:
            begin
                // walk down from the tail, each entry moves up one slot
                cmd.shift_rd = 1'b1;
                cmd.shift_up = 1'b1;
                if (stat.p_eq_at)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_CLOSE:
            begin
                // walk up from the hole, each entry moves down one slot
                cmd.shift_rd = 1'b1;
                if (stat.p_eq_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.kind == KIND_REMOVE)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/isl_dp.sv
// Datapath for the indexed sequence list: value memory, length count, shift
// pointer, request latch and response register. Depends on isl_pkg, isl_if.
`default_nettype none

module isl_dp
    import isl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    isl_req_if.sink      req,
    isl_rsp_if.source    rsp,
    input  wire cmd_t    cmd,
    output stat_t        stat
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CEXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    logic [VAL_W-1:0]    mem [CAPACITY];
    logic [VAL_W-1:0]    rd_data_reg;

    logic [CNT_W-1:0]    count_reg;
    logic                pend_reg;
    logic [AW-1:0]       wa_reg;
    logic [AW-1:0]       p_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [VAL_W-1:0]    item_reg;
    logic [CMP_W-1:0]    pos_reg;
    logic [CMP_W-1:0]    at_reg;

    logic [VAL_W-1:0]    res_val_reg;
    status_t             res_st_reg;

    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_val_reg;
    logic [STATUS_W-1:0] out_st_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    count_m1;
    logic [CMP_W-1:0]    at_p1;
    logic [CMP_W-1:0]    p_ext;
    logic [CEXT_W-1:0]   count_out_ext;
    logic [CMP_W-1:0]    pos_in_ext;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [VAL_W-1:0]    mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;
    logic [AW-1:0]       place_addr;

    assign count_ext     = CMP_W'(count_reg);
    assign count_m1      = count_ext - CMP_W'(1);
    assign at_p1         = at_reg + CMP_W'(1);
    assign p_ext         = CMP_W'(p_reg);
    assign count_out_ext = CEXT_W'(count_reg);
    assign pos_in_ext    = CMP_W'(req.position);

    // status toward the controller
    always_comb
    begin
        stat            = '0;
        stat.in_valid   = req.valid;
        stat.out_busy   = out_valid_reg & ~rsp.ready;
        stat.kind       = kind_reg;
        stat.pos_ok     = pos_reg < count_ext;
        stat.full       = count_reg == CNT_W'(CAPACITY);
        stat.empty      = count_reg == '0;
        stat.at_is_last = at_reg == count_m1;
        stat.p_eq_at    = p_ext == at_reg;
        stat.p_eq_last  = p_ext == count_m1;
    end

    // one write port: pending shift write or placement, never both
    assign place_addr = (kind_reg == KIND_END) ? count_reg[AW-1:0] : at_reg[AW-1:0];
    assign mem_we     = pend_reg | cmd.place;
    assign mem_wa     = pend_reg ? wa_reg : place_addr;
    assign mem_wd     = pend_reg ? rd_data_reg : item_reg;
    assign mem_re     = cmd.shift_rd | cmd.rd_issue;
    assign mem_ra     = cmd.rd_issue ? pos_reg[AW-1:0] : p_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.shift_rd;
            if (cmd.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg    <= req.kind;
            item_reg    <= req.item_value;
            pos_reg     <= pos_in_ext;
            at_reg      <= (req.kind == KIND_FRONT) ? '0 : pos_in_ext;
            res_val_reg <= '0;
            res_st_reg  <= ST_DONE;
        end
        if (cmd.ptr_open)
        begin
            p_reg <= count_m1[AW-1:0];
        end
        else if (cmd.ptr_close)
        begin
            p_reg <= at_p1[AW-1:0];
        end
        else if (cmd.shift_rd)
        begin
            p_reg <= cmd.shift_up ? (p_reg - AW'(1)) : (p_reg + AW'(1));
        end
        if (cmd.shift_rd)
        begin
            wa_reg <= cmd.shift_up ? (p_reg + AW'(1)) : (p_reg - AW'(1));
        end
        if (cmd.rd_capture)
        begin
            res_val_reg <= rd_data_reg;
        end
        if (cmd.set_status)
        begin
            res_st_reg <= cmd.status;
        end
        if (cmd.publish)
        begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
            out_cnt_reg <= count_out_ext[CNT_OUT_W-1:0];
        end
    end

    assign req.ready      = cmd.in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_val_reg;
    assign rsp.status     = out_st_reg;
    assign rsp.count      = out_cnt_reg;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_sequence_list.sv
// Indexed sequence list: bounded ordered list of signed 32-bit values.
// Adds at the front or at p shift every entry from the insert point up; removes at p
// shift every entry above p down; adds at the end and removes at the tail need no shift.
// One memory port pair: shifting moves one entry per cycle. One request in flight at a time;
// the next is taken while a response still waits.
// Async active-low reset empties the list (count 0); stored values are not cleared.
`default_nettype none

module indexed_sequence_list
    import isl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    isl_req_if.sink     req,
    isl_rsp_if.source   rsp
);

    // Controller and datapath talk only through these two structs.
    cmd_t  cmd;
    stat_t stat;

    // Sequencer: decodes the latched request, runs the gap walk and hands
    // the result to the response register once it is free.
    isl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage, length count, walk pointer and response register.
    isl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

// File: verif/isl_list_checker.sv
// Response checker for the indexed sequence list: predicts each request's result from a
// shadow copy of the list and compares it with what comes back on the response channel.
// Depends on isl_pkg and the isl_req_if / isl_rsp_if interfaces.

module isl_list_checker
    import isl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    isl_req_if                    req,
    isl_rsp_if                    rsp,
    output logic [CNT_OUT_W-1:0]  list_len,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        status_t                 status;
        logic [CNT_OUT_W-1:0]    count;
    } list_result_t;

    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int                      shadow_len;
    list_result_t            expected_q [$];
    list_result_t            want;
    int                      mismatches = 0;

    assign fail_count = mismatches;

    // Applies one request to the shadow list and returns the result it should produce.
    function automatic list_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                   input logic signed [VAL_W-1:0] value,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        logic         pos_ok;
        logic         full;
        int           at;
        int           k;
        r.read_value = '0;
        r.status     = ST_DONE;
        pos_ok       = int'(pos) < shadow_len;
        full         = shadow_len >= DEPTH;
        case (kind)
            KIND_READ:
                if (pos_ok)
                    r.read_value = shadow_list[pos];
                else
                    r.status = ST_BAD;
            KIND_FRONT, KIND_END, KIND_INSERT:
            begin
                if (kind == KIND_INSERT && !pos_ok)
                    r.status = ST_BAD;
                else if (full)
                    r.status = ST_FULL;
                else
                begin
                    at = (kind == KIND_FRONT) ? 0 : (kind == KIND_END) ? shadow_len : int'(pos);
                    for (k = shadow_len; k > at; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[at] = value;
                    shadow_len++;
                end
            end
            KIND_REMOVE:
            begin
                if (pos_ok)
                begin
                    for (k = int'(pos); k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                end
                else
                    r.status = ST_BAD;
            end
            default:
                r.status = ST_BAD;
        endcase
        r.count = CNT_OUT_W'(shadow_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_q.delete();
            list_len <= '0;
            pending  <= 0;
        end
        else
        begin
            // responses first: a request taken at this edge cannot be answered at it
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $error("response with nothing outstanding: read_value %0d status %0d count %0d",
                           rsp.read_value, rsp.status, rsp.count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.read_value !== want.read_value)
                    begin
                        mismatches++;
                        $error("read_value mismatch: expected %0d, got %0d",
                               want.read_value, rsp.read_value);
                    end
                    if (rsp.status !== want.status)
                    begin
                        mismatches++;
                        $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
                    end
                    if (rsp.count !== want.count)
                    begin
                        mismatches++;
                        $error("count mismatch: expected %0d, got %0d", want.count, rsp.count);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(apply_request(req.kind, req.item_value, req.position));
            list_len <= CNT_OUT_W'(shadow_len);
            pending  <= expected_q.size();
        end
    end

endmodule

// File: verif/tb_indexed_sequence_list.sv
// Top-level bench for indexed_sequence_list: clock, reset, request stimulus, response
// back-pressure, watchdog and verdict. Depends on isl_pkg, the isl interfaces and isl_list_checker.

module tb_indexed_sequence_list;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 900;
    localparam int IDLE_PCT       = 22;
    localparam int MAX_GAP        = 4;
    // no idling on either side for this window of the random part
    localparam int STEADY_FIRST   = 350;
    localparam int STEADY_LAST    = 500;
    localparam int FULL_EXTRA     = 8;
    localparam int EMPTY_EXTRA    = 4;
    localparam int CHURN_ITEMS    = 80;
    // slowest transfer is a front insert on a near-full list plus stalls
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY_DEF;

    // request codes the block does not define; they must come back as bad requests
    localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;

    // Random traffic walks the list through its whole range: fill to capacity, poke
    // at the full list, drain to empty, poke at the empty list, then mixed churn.
    typedef enum logic [2:0] {
        PH_GROW,
        PH_AT_FULL,
        PH_SHRINK,
        PH_AT_EMPTY,
        PH_CHURN
    } stim_phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 steady = 1'b0;
    int                   idle_cycles = 0;
    logic [CNT_OUT_W-1:0] list_len;
    int                   pending;
    int                   fail_count;

    isl_req_if req_bus ();
    isl_rsp_if rsp_bus ();

    indexed_sequence_list uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    isl_list_checker list_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_bus),
        .rsp        (rsp_bus),
        .list_len   (list_len),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Response back-pressure: ready drops in about IDLE_PCT of cycles, never while steady.
    always @(posedge clk)
        rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("indexed_sequence_list regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly arbitrary 32-bit values, with the signed extremes, zero and -1 mixed in.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Positions lean toward the occupied range so reads, inserts and removes mostly land;
    // the rest hit the length itself (bad for insert) or anywhere in the 6-bit range.
    // list_len may trail by the request just taken, which only shifts the bias.
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (list_len != 0 && r < 80)
            return POS_W'($urandom_range(0, list_len - 1));
        if (r < 90 && list_len < CAPACITY_DEF)
            return POS_W'(list_len);
        return POS_W'($urandom_range(0, CAPACITY_DEF - 1));
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input stim_phase_t phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_GROW:
                if (r < 25) return KIND_FRONT;
                else if (r < 55) return KIND_END;
                else if (r < 80) return KIND_INSERT;
                else if (r < 88) return KIND_READ;
                else if (r < 97) return KIND_REMOVE;
            PH_AT_FULL:
                if (r < 25) return KIND_FRONT;
                else if (r < 50) return KIND_END;
                else if (r < 80) return KIND_INSERT;
                else if (r < 95) return KIND_READ;
            PH_SHRINK:
                if (r < 65) return KIND_REMOVE;
                else if (r < 80) return KIND_READ;
                else if (r < 85) return KIND_FRONT;
                else if (r < 90) return KIND_END;
                else if (r < 97) return KIND_INSERT;
            PH_AT_EMPTY:
                if (r < 30) return KIND_READ;
                else if (r < 60) return KIND_REMOVE;
                else if (r < 85) return KIND_INSERT;
            default:
                if (r < 15) return KIND_FRONT;
                else if (r < 30) return KIND_END;
                else if (r < 50) return KIND_INSERT;
                else if (r < 70) return KIND_READ;
                else if (r < 95) return KIND_REMOVE;
        endcase
        return KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    endfunction

    // One request transfer. An optional idle gap goes first, with junk on the payload;
    // returns at the edge where the transfer happened, valid still high.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [VAL_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            req_bus.valid      <= 1'b0;
            req_bus.kind       <= KIND_W'($urandom);
            req_bus.item_value <= $urandom;
            req_bus.position   <= POS_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.kind       <= kind;
        req_bus.item_value <= value;
        req_bus.position   <= pos;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    initial
    begin
        stim_phase_t phase;
        int          phase_items;
        int          n;
        int          k;

        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.kind       <= KIND_READ;
        req_bus.item_value <= '0;
        req_bus.position   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty list, undefined codes, value extremes, edges of the list ---
        send_request(KIND_READ, 32'sd1, 6'd0);          // empty list: bad position
        send_request(KIND_REMOVE, 32'sd2, 6'd0);
        send_request(KIND_INSERT, 32'sd3, 6'd0);
        for (k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
            send_request(KIND_W'(k), pick_value(), pick_position());
        send_request(KIND_END, 32'sh7fff_ffff, 6'd63);  // position ignored on adds
        send_request(KIND_FRONT, 32'sh8000_0000, 6'd0);
        send_request(KIND_END, 32'sd0, 6'd0);
        send_request(KIND_INSERT, -32'sd1, 6'd1);       // [min, -1, max, 0]
        send_request(KIND_INSERT, 32'sd5, 6'd4);        // at the length: bad position
        send_request(KIND_INSERT, 32'sd1, 6'd0);        // before the head
        send_request(KIND_READ, 32'sd0, 6'd0);
        send_request(KIND_READ, 32'sd0, 6'd4);          // tail
        send_request(KIND_READ, 32'sd0, 6'd5);          // one past the tail
        send_request(KIND_READ, 32'sd0, 6'd63);
        send_request(KIND_REMOVE, 32'sd0, 6'd4);        // tail
        send_request(KIND_REMOVE, 32'sd0, 6'd0);        // head
        send_request(KIND_REMOVE, 32'sd0, 6'd1);        // middle
        send_request(KIND_READ, 32'sd0, 6'd1);
        send_request(KIND_REMOVE, 32'sd0, 6'd63);

        // --- random: phased walk between empty and full ---
        phase       = PH_GROW;
        phase_items = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
            send_request(pick_kind(phase), pick_value(), pick_position());
            phase_items++;
            case (phase)
                PH_GROW:
                    if (list_len >= CAPACITY_DEF)
                    begin
                        phase       = PH_AT_FULL;
                        phase_items = 0;
                    end
                PH_AT_FULL:
                    if (phase_items >= FULL_EXTRA)
                    begin
                        phase       = PH_SHRINK;
                        phase_items = 0;
                    end
                PH_SHRINK:
                    if (list_len == 0)
                    begin
                        phase       = PH_AT_EMPTY;
                        phase_items = 0;
                    end
                PH_AT_EMPTY:
                    if (phase_items >= EMPTY_EXTRA)
                    begin
                        phase       = PH_CHURN;
                        phase_items = 0;
                    end
                default:
                    if (phase_items >= CHURN_ITEMS)
                    begin
                        phase       = PH_GROW;
                        phase_items = 0;
                    end
            endcase
        end
        steady = 1'b0;
        req_bus.valid <= 1'b0;

        // let the checker see the last transfer, wait for every response, then
        // give stray responses a window to show up
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("indexed_sequence_list regression: pass");
        else
            $display("indexed_sequence_list regression: fail");
        $finish;
    end

endmodule
